@@ rtl/adtf_pkg.sv @@
// ============================================================================
// adtf_pkg
// Shared types and constants of the ASCII decimal to fixed point parser.
// ============================================================================
`default_nettype none

package adtf_pkg;

	// Character codes that the parser recognizes.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_DIGIT = 2'd1;
	localparam logic [1:0] ST_TWO_PTS  = 2'd2;
	localparam logic [1:0] ST_INT_SAT  = 2'd3;

	// Depth of the queues between front, back and result port.
	localparam int QUEUE_DEPTH = 2;

	// Fraction digit weight index: the weight reaches zero after nine steps.
	localparam int WIDX_W = 4;
	localparam logic [WIDX_W-1:0] WIDX_LAST = 4'd9;

	typedef enum logic [1:0] {
		CL_DIGIT = 2'd0,
		CL_MINUS = 2'd1,
		CL_POINT = 2'd2,
		CL_OTHER = 2'd3
	} char_class_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic        start_req;
		char_class_t cls;
		logic [3:0]  digit;
	} cls_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
		logic [7:0]         chars_used;
	} out_item_t;

	// Weight of a fraction digit in units of 2^-32. It starts at one tenth
	// rounded up and is divided by ten with truncation for each digit.
	function automatic logic [31:0] frac_weight(input logic [WIDX_W-1:0] idx);
		logic [31:0] w;
		unique case (idx)
			4'd0:    w = 32'h1999999A;
			4'd1:    w = 32'd42949673;
			4'd2:    w = 32'd4294967;
			4'd3:    w = 32'd429496;
			4'd4:    w = 32'd42949;
			4'd5:    w = 32'd4294;
			4'd6:    w = 32'd429;
			4'd7:    w = 32'd42;
			4'd8:    w = 32'd4;
			default: w = 32'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/adtf_fifo.sv @@
// ============================================================================
// adtf_fifo
// Small register queue with full and empty flags.
// ============================================================================
`default_nettype none

module adtf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             wr;
	logic             rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ rtl/adtf_front.sv @@
// ============================================================================
// adtf_front
// Character classifier: sorts each character into digit, sign, point or
// terminator and extracts the digit value.
// ============================================================================
`default_nettype none

module adtf_front (
	input  wire logic              push,
	input  wire logic              q_full,
	input  wire adtf_pkg::in_item_t item,
	output logic                   q_push,
	output adtf_pkg::cls_item_t    q_item
);

	assign q_push = push && !q_full;

	always_comb begin
		q_item.start_req = item.start_req;
		q_item.digit     = 4'(item.char_code - adtf_pkg::CH_ZERO);
		unique case (item.char_code) inside
			[adtf_pkg::CH_ZERO:adtf_pkg::CH_NINE]: q_item.cls = adtf_pkg::CL_DIGIT;
			adtf_pkg::CH_MINUS:                    q_item.cls = adtf_pkg::CL_MINUS;
			adtf_pkg::CH_POINT:                    q_item.cls = adtf_pkg::CL_POINT;
			default:                               q_item.cls = adtf_pkg::CL_OTHER;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/adtf_back.sv @@
// ============================================================================
// adtf_back
// Parser state machine with integer and fraction accumulators. Takes one
// classified character per cycle unless res_full; a result closes the number.
// ============================================================================
`default_nettype none

module adtf_back #(
	parameter int FRAC_BITS = 32,
	parameter int INT_BITS  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire adtf_pkg::cls_item_t item,
	output logic                    item_pop,
	input  wire logic               res_full,
	output logic                    res_push,
	output adtf_pkg::out_item_t     res
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_NEED = 4'b0010,
		PH_INT  = 4'b0100,
		PH_FRAC = 4'b1000
	} phase_t;

	localparam int IW = INT_BITS + 4;
	localparam logic [INT_BITS-1:0] INT_MAX = INT_BITS'((64'd1 << (INT_BITS - 1)) - 64'd1);

	phase_t                   phase_q, phase_d;
	logic                     neg_q, neg_d;
	logic [INT_BITS-1:0]      int_acc_q, int_acc_d;
	logic                     int_sat_q, int_sat_d;
	logic [31:0]              frac_acc_q, frac_acc_d;
	logic [adtf_pkg::WIDX_W-1:0] widx_q, widx_d;
	logic [7:0]               count_q, count_d;

	logic                     fire;
	logic                     emit;
	logic [1:0]               emit_status;
	logic [7:0]               count_inc;
	logic [IW-1:0]            int_sum;
	logic                     int_over;
	logic [35:0]              frac_prod;
	logic [36:0]              frac_sum;
	logic [31:0]              frac_new;
	logic [FRAC_BITS-1:0]     frac_field;
	logic [63:0]              mag;

	assign fire     = item_valid && !res_full;
	assign item_pop = fire;

	assign count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

	// Integer step: acc * 10 + d, clamped to the largest positive value.
	assign int_sum  = (IW'(int_acc_q) << 3) + (IW'(int_acc_q) << 1) + IW'(item.digit);
	assign int_over = (int_sum > IW'(INT_MAX));

	// Fraction step: acc + d * weight, clamped at all ones.
	assign frac_prod = 36'(item.digit) * 36'(adtf_pkg::frac_weight(widx_q));
	assign frac_sum  = 37'(frac_acc_q) + 37'(frac_prod);
	assign frac_new  = (frac_sum > 37'h0FFFFFFFF) ? 32'hFFFFFFFF : frac_sum[31:0];

	always_comb begin
		phase_d     = phase_q;
		neg_d       = neg_q;
		int_acc_d   = int_acc_q;
		int_sat_d   = int_sat_q;
		frac_acc_d  = frac_acc_q;
		widx_d      = widx_q;
		count_d     = count_q;
		emit        = 1'b0;
		emit_status = adtf_pkg::ST_OK;

		if (item.start_req) begin
			phase_d    = PH_IDLE;
			neg_d      = 1'b0;
			int_acc_d  = '0;
			int_sat_d  = 1'b0;
			frac_acc_d = '0;
			widx_d     = '0;
			count_d    = '0;
			case (item.cls)
				adtf_pkg::CL_MINUS: begin
					neg_d   = 1'b1;
					phase_d = PH_NEED;
					count_d = 8'd1;
				end
				adtf_pkg::CL_DIGIT: begin
					int_acc_d = INT_BITS'(item.digit);
					phase_d   = PH_INT;
					count_d   = 8'd1;
				end
				default: begin
					emit        = 1'b1;
					emit_status = adtf_pkg::ST_NO_DIGIT;
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_NEED: begin
					if (item.cls == adtf_pkg::CL_DIGIT) begin
						int_acc_d = int_over ? INT_MAX : int_sum[INT_BITS-1:0];
						int_sat_d = int_sat_q || int_over;
						phase_d   = PH_INT;
						count_d   = count_inc;
					end else begin
						emit        = 1'b1;
						emit_status = adtf_pkg::ST_NO_DIGIT;
					end
				end
				PH_INT: begin
					if (item.cls == adtf_pkg::CL_DIGIT) begin
						int_acc_d = int_over ? INT_MAX : int_sum[INT_BITS-1:0];
						int_sat_d = int_sat_q || int_over;
						count_d   = count_inc;
					end else if (item.cls == adtf_pkg::CL_POINT) begin
						phase_d = PH_FRAC;
						count_d = count_inc;
					end else begin
						emit = 1'b1;
					end
				end
				PH_FRAC: begin
					if (item.cls == adtf_pkg::CL_DIGIT) begin
						frac_acc_d = frac_new;
						widx_d     = (widx_q == adtf_pkg::WIDX_LAST) ? widx_q : widx_q + 1'b1;
						count_d    = count_inc;
					end else if (item.cls == adtf_pkg::CL_POINT) begin
						emit        = 1'b1;
						emit_status = adtf_pkg::ST_TWO_PTS;
					end else begin
						emit = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// Every result closes the number.
		if (emit) begin
			phase_d    = PH_IDLE;
			neg_d      = 1'b0;
			int_acc_d  = '0;
			int_sat_d  = 1'b0;
			frac_acc_d = '0;
			widx_d     = '0;
			count_d    = '0;
		end
	end

	// Result assembly from the state that the number reached before its end.
	assign frac_field = int_sat_q ? '1 : frac_acc_q[31 -: FRAC_BITS];
	assign mag        = (64'(int_acc_q) << FRAC_BITS) | 64'(frac_field);

	always_comb begin
		res.chars_used = item.start_req ? 8'd0 : count_q;
		if (emit_status == adtf_pkg::ST_OK) begin
			res.status = int_sat_q ? adtf_pkg::ST_INT_SAT : adtf_pkg::ST_OK;
			res.value  = neg_q ? -$signed(mag) : $signed(mag);
		end else begin
			res.status = emit_status;
			res.value  = '0;
		end
	end

	assign res_push = fire && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			neg_q      <= 1'b0;
			int_acc_q  <= '0;
			int_sat_q  <= 1'b0;
			frac_acc_q <= '0;
			widx_q     <= '0;
			count_q    <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			int_acc_q  <= int_acc_d;
			int_sat_q  <= int_sat_d;
			frac_acc_q <= frac_acc_d;
			widx_q     <= widx_d;
			count_q    <= count_d;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		int_sat_q |-> (int_acc_q == INT_MAX))
		else $error("saturated integer part is not at its maximum");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (count_q == 8'd0 && !neg_q && int_acc_q == '0))
		else $error("idle parser holds a partial number");

	a_widx_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(widx_q != '0) |-> (phase_q == PH_FRAC))
		else $error("fraction weight advanced outside the fraction part");

	a_emit_close: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (phase_q == PH_IDLE && count_q == 8'd0))
		else $error("number not closed after its result");

endmodule

`default_nettype wire

@@ rtl/ascii_decimal_to_fixed.sv @@
// ============================================================================
// ascii_decimal_to_fixed
// Streaming parser of ASCII decimal numbers into signed fixed point.
// ============================================================================
// Throughput: one character item per cycle, sustained, with pop held high.
// A terminating item is registered in the classified item queue, then the
//   parser stage writes its result into the result queue (empty low).
// The parser stage consumes one classified item per cycle while the result
//   queue has room, so an item can enter while a result waits to be popped.
// Reset: arst_n clears the queues and the parser state at once; no
//   clearing pass is needed and an item can be pushed right after reset.
// ============================================================================
`default_nettype none

module ascii_decimal_to_fixed #(
	parameter int FRAC_BITS = 32,
	parameter int INT_BITS  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire adtf_pkg::in_item_t item,
	output logic                    empty,
	input  wire logic               pop,
	output adtf_pkg::out_item_t     result
);

	// The front classifies each character as it is pushed and writes the
	// class and digit value into a short queue. The parser in the back
	// drains that queue at one item per cycle whenever the result queue has
	// room, so either side can stall without stopping the other at once.

	localparam int CLS_W = $bits(adtf_pkg::cls_item_t);
	localparam int OUT_W = $bits(adtf_pkg::out_item_t);

	logic                mid_push;
	logic                mid_full;
	logic                mid_empty;
	logic                mid_pop;
	adtf_pkg::cls_item_t mid_wdata;
	adtf_pkg::cls_item_t mid_rdata;
	logic                res_push;
	logic                res_full;
	adtf_pkg::out_item_t res_wdata;

	// The input side looks full exactly when the classified item queue is.
	assign full = mid_full;

	adtf_front u_front (
		.push   (push),
		.q_full (mid_full),
		.item   (item),
		.q_push (mid_push),
		.q_item (mid_wdata)
	);

	adtf_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (adtf_pkg::QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	// The parser keeps the sign, the integer and fraction accumulators, the
	// fraction digit weight and the character count of the open number.
	// A terminator, a missing digit or a second point produces one result.
	adtf_back #(
		.FRAC_BITS (FRAC_BITS),
		.INT_BITS  (INT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!mid_empty),
		.item       (mid_rdata),
		.item_pop   (mid_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_wdata)
	);

	// Results wait here until popped; the oldest one is always on the port.
	adtf_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (adtf_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench of ascii_decimal_to_fixed
// Feeds ASCII character items through the push/full side, predicts every
// parsed number with an independent model of the parser, and checks each
// popped result against the oldest prediction; random idling varies by test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int FRAC_BITS = 32;
	localparam int INT_BITS  = 32;

	// Fraction digit weight at the start of every number: one tenth, rounded up.
	localparam logic [31:0] WEIGHT_START = 32'h1999_999A;
	// Largest magnitude that the integer part may hold before it saturates.
	localparam logic [63:0] INT_LIMIT = (64'd1 << (INT_BITS - 1)) - 64'd1;

	// Where the parser stands inside a number.
	typedef enum logic [1:0] {
		P_IDLE = 2'd0,
		P_NEED = 2'd1,
		P_INT  = 2'd2,
		P_FRAC = 2'd3
	} parse_phase_t;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	adtf_pkg::in_item_t  item;
	logic                empty;
	logic                pop;
	adtf_pkg::out_item_t result;

	// Predictor state, a private copy of what the parser holds for one number.
	parse_phase_t pr_phase;
	logic         pr_negative;
	logic [31:0]  pr_int_acc;
	logic [31:0]  pr_frac_acc;
	logic [31:0]  pr_weight;
	logic [7:0]   pr_count;
	logic         pr_sat;

	// Parsed numbers that have been predicted but not yet popped.
	adtf_pkg::out_item_t pending_numbers[$];

	int mismatches    = 0;
	int chars_parsed  = 0;   // items that the parser did not merely ignore
	int src_idle_pct  = 0;   // chance in percent that a gap precedes an item
	int sink_idle_pct = 0;   // chance in percent that pop drops for a while
	int sink_hold     = 0;

	ascii_decimal_to_fixed #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS (INT_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// About one idle stretch in twenty is a long one, so that the result queue
	// fills and full is raised.
	function automatic int idle_length();
		if ($urandom_range(19) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	task automatic clear_number();
		pr_phase    = P_IDLE;
		pr_negative = 1'b0;
		pr_int_acc  = '0;
		pr_frac_acc = '0;
		pr_weight   = WEIGHT_START;
		pr_count    = '0;
		pr_sat      = 1'b0;
	endtask

	task automatic count_char();
		if (pr_count != 8'hFF)
			pr_count = pr_count + 8'd1;
	endtask

	task automatic add_int_digit(input logic [3:0] d);
		logic [63:0] v;
		v = {32'd0, pr_int_acc} * 64'd10 + {60'd0, d};
		if (v > INT_LIMIT) begin
			v = INT_LIMIT;
			pr_sat = 1'b1;
		end
		pr_int_acc = v[31:0];
	endtask

	task automatic add_frac_digit(input logic [3:0] d);
		logic [63:0] v;
		v = {32'd0, pr_frac_acc} + {60'd0, d} * {32'd0, pr_weight};
		if (v > 64'h0000_0000_FFFF_FFFF)
			v = 64'h0000_0000_FFFF_FFFF;
		pr_frac_acc = v[31:0];
		pr_weight   = pr_weight / 32'd10;
	endtask

	// Closes the open number: builds the fixed point value, queues the
	// prediction and returns the parser to idle. Error results carry zero.
	task automatic finish_number(input logic [1:0] status);
		adtf_pkg::out_item_t r;
		logic [63:0]         mag;
		logic [63:0]         frac;
		logic [1:0]          st;
		mag = '0;
		st  = status;
		if (st == adtf_pkg::ST_OK || st == adtf_pkg::ST_INT_SAT) begin
			frac = {32'd0, pr_frac_acc >> (32 - FRAC_BITS)};
			if (pr_sat) begin
				st   = adtf_pkg::ST_INT_SAT;
				frac = (64'd1 << FRAC_BITS) - 64'd1;
			end
			mag = ({32'd0, pr_int_acc} << FRAC_BITS) | frac;
			if (pr_negative)
				mag = ~mag + 64'd1;
		end
		r.value      = mag;
		r.status     = st;
		r.chars_used = pr_count;
		pending_numbers.push_back(r);
		clear_number();
	endtask

	// Advances the predictor by one accepted character item.
	task automatic parse_char(input logic start, input logic [7:0] c);
		logic       is_digit;
		logic [3:0] d;
		is_digit = (c >= adtf_pkg::CH_ZERO) && (c <= adtf_pkg::CH_NINE);
		d = is_digit ? 4'(c - adtf_pkg::CH_ZERO) : 4'd0;
		if (!start && pr_phase == P_IDLE)
			return;
		chars_parsed++;
		if (start) begin
			// A start drops any open number without a result.
			clear_number();
			if (c == adtf_pkg::CH_MINUS) begin
				pr_negative = 1'b1;
				pr_phase    = P_NEED;
				count_char();
			end else if (is_digit) begin
				add_int_digit(d);
				pr_phase = P_INT;
				count_char();
			end else begin
				finish_number(adtf_pkg::ST_NO_DIGIT);
			end
			return;
		end
		case (pr_phase)
			P_NEED: begin
				if (!is_digit) begin
					finish_number(adtf_pkg::ST_NO_DIGIT);
				end else begin
					add_int_digit(d);
					pr_phase = P_INT;
					count_char();
				end
			end
			P_INT: begin
				if (is_digit) begin
					add_int_digit(d);
					count_char();
				end else if (c == adtf_pkg::CH_POINT) begin
					pr_phase = P_FRAC;
					count_char();
				end else begin
					finish_number(adtf_pkg::ST_OK);
				end
			end
			P_FRAC: begin
				if (is_digit) begin
					add_frac_digit(d);
					count_char();
				end else if (c == adtf_pkg::CH_POINT) begin
					finish_number(adtf_pkg::ST_TWO_PTS);
				end else begin
					finish_number(adtf_pkg::ST_OK);
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Sender and result checker
	// ------------------------------------------------------------------------

	// Sends one character item. The caller is at a rising edge. full is
	// sampled at the falling edge, where it is stable, and the item counts as
	// accepted at the next rising edge when full was low there.
	task automatic send_char(input logic start, input logic [7:0] c);
		logic was_full;
		if ($urandom_range(99) < src_idle_pct) begin
			push <= 1'b0;
			repeat (idle_length()) @(posedge clk);
		end
		push           <= 1'b1;
		item.start_req <= start;
		item.char_code <= c;
		forever begin
			@(negedge clk);
			was_full = full;
			@(posedge clk);
			if (!was_full)
				break;
		end
		parse_char(start, c);
	endtask

	// Sends a string; its first character opens a new number.
	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(i == 0, s[i]);
	endtask

	// Continues an open number with the characters of a string.
	task automatic send_text_tail(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(1'b0, s[i]);
	endtask

	function automatic logic [7:0] random_digit();
		return adtf_pkg::CH_ZERO + 8'($urandom_range(9));
	endfunction

	// Any code that is neither a digit nor a point.
	function automatic logic [7:0] random_terminator();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while ((c >= adtf_pkg::CH_ZERO && c <= adtf_pkg::CH_NINE) ||
			c == adtf_pkg::CH_POINT);
		return c;
	endfunction

	// pop is changed only at rising edges; the sink drops it for random
	// stretches when sink_idle_pct asks for it.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (sink_hold > 0) begin
			pop <= 1'b0;
			sink_hold = sink_hold - 1;
		end else if ($urandom_range(99) < sink_idle_pct) begin
			pop <= 1'b0;
			sink_hold = idle_length() - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	// At the falling edge pop, empty and result are all stable. When pop is
	// high and empty low, the result on the port is taken at the next rising
	// edge, so it is compared here against the oldest prediction.
	always @(negedge clk) begin
		adtf_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_numbers.size() == 0) begin
				$display("%0t: result with nothing expected: value %h status %0d used %0d",
					$realtime, result.value, result.status, result.chars_used);
				mismatches++;
			end else begin
				want = pending_numbers.pop_front();
				if (result.value !== want.value) begin
					$display("%0t: value mismatch: expected %h actual %h",
						$realtime, want.value, result.value);
					mismatches++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d",
						$realtime, want.status, result.status);
					mismatches++;
				end
				if (result.chars_used !== want.chars_used) begin
					$display("%0t: chars_used mismatch: expected %0d actual %0d",
						$realtime, want.chars_used, result.chars_used);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Hand-picked numbers for the edges of the format and every status.
	task automatic test_directed();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		// A character without a start while idle is ignored.
		send_char(1'b0, "7");
		send_text("0 ");
		// Negative zero comes out as plain zero.
		send_text("-0,");
		// A trailing point is accepted as an integer.
		send_text("5.x");
		send_text("-123.456 ");
		send_text("2147483647-");
		// Integer part too large saturates on both signs.
		send_text("99999999999.5 ");
		send_text("-4294967296;");
		// A second decimal point is an error.
		send_text("1.2.");
		// Missing digits: after a minus, as the first character, two minuses.
		send_text("-x");
		send_text(".");
		send_text("--");
		// A new start drops the open number without a result.
		send_text("12");
		send_text("7 ");
		// Enough fraction digits that the weight runs down to zero.
		send_text("0.999999999999 ");
		// Extreme character codes, as terminator and as a bad first character.
		send_char(1'b1, "3");
		send_char(1'b0, 8'hFF);
		send_char(1'b1, 8'h00);
		send_char(1'b1, 8'hFF);
		send_char(1'b1, "8");
		send_char(1'b0, 8'h00);
	endtask

	// A number longer than 255 characters; chars_used saturates in the
	// integer part and stays there through the fraction.
	task automatic test_long_number();
		int i;
		src_idle_pct  = 10;
		sink_idle_pct = 10;
		send_text("-");
		for (i = 0; i < 255; i++)
			send_char(1'b0, "0");
		send_text_tail("1.5");
		for (i = 0; i < 10; i++)
			send_char(1'b0, "9");
		send_char(1'b0, "z");
	endtask

	// Mostly well formed numbers with random content; the rest are broken
	// numbers, restarts and plain noise.
	task automatic test_random_numbers();
		int kind;
		int n_int;
		int n_frac;
		int i;
		int goal;
		logic has_point;
		goal = chars_parsed + 450;
		while (chars_parsed < goal) begin
			// Cycle through idling setups, one of them with no idling at all.
			case (((goal - chars_parsed) / 100) % 4)
				0: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
				1: begin src_idle_pct = 30; sink_idle_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_idle_pct = 40; end
				default: begin src_idle_pct = 30; sink_idle_pct = 30; end
			endcase
			kind = $urandom_range(99);
			if (kind < 75) begin
				n_int     = ($urandom_range(9) == 0) ? $urandom_range(10, 12)
				                                     : $urandom_range(1, 6);
				has_point = ($urandom_range(9) < 6);
				n_frac    = has_point ? $urandom_range(0, 11) : 0;
				if ($urandom_range(2) == 0)
					send_char(1'b1, adtf_pkg::CH_MINUS);
				else
					send_char(1'b1, random_digit());
				for (i = 0; i < n_int - 1; i++)
					send_char(1'b0, random_digit());
				if (has_point) begin
					send_char(1'b0, adtf_pkg::CH_POINT);
					for (i = 0; i < n_frac; i++)
						send_char(1'b0, random_digit());
				end
				// A lone opening character sometimes gets one more digit.
				if (n_int == 1 && !has_point && $urandom_range(1) == 0)
					send_char(1'b0, random_digit());
				if (has_point && $urandom_range(9) == 0)
					send_char(1'b0, adtf_pkg::CH_POINT);
				else
					send_char(1'b0, random_terminator());
			end else if (kind < 85) begin
				case ($urandom_range(2))
					0: begin
						send_char(1'b1, adtf_pkg::CH_MINUS);
						send_char(1'b0, random_terminator());
					end
					1: send_char(1'b1, random_terminator());
					default: begin
						// Left open on purpose: the next start drops it.
						send_char(1'b1, random_digit());
						for (i = 0; i < $urandom_range(0, 4); i++)
							send_char(1'b0, random_digit());
					end
				endcase
			end else begin
				for (i = 0; i < $urandom_range(1, 6); i++)
					send_char(1'($urandom_range(1)), 8'($urandom_range(255)));
			end
		end
		// Close whatever number noise or a restart left open.
		send_char(1'b0, random_terminator());
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		clear_number();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_long_number();
		test_random_numbers();

		push <= 1'b0;
		while (pending_numbers.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
